// ===== hdl/sra_pkg.sv =====
// Shared types and constants for the slot range allocator.
package sra_pkg;

  localparam int SLOT_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int COUNT_REG_W = 2;

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [1:0]             status_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Result codes.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NO_RANGE = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Register indexes.
  localparam cfg_index_t REG_RANGE_COUNT = 3'd0;
  localparam cfg_index_t REG_RANGE0_LOW  = 3'd1;
  localparam cfg_index_t REG_RANGE0_HIGH = 3'd2;
  localparam cfg_index_t REG_RANGE1_LOW  = 3'd3;
  localparam cfg_index_t REG_RANGE1_HIGH = 3'd4;

  typedef struct packed {
    slot_t   slot;
    status_t status;
  } result_t;

endpackage

// ===== hdl/sra_stack_mem.sv =====
// Single-port-write, single-port-read memory holding the freed-slot stacks.
module sra_stack_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/slot_range_allocator_core.sv =====
// Top level of the slot range allocator: range registers, bump pointers and stack control.
//
// The allocator hands out slot numbers from up to NUM_RANGES ranges [low, high),
// tried in order, and takes them back. Each range has a bump pointer and a LIFO
// stack of freed slots; the stacks of all ranges share one memory of
// NUM_RANGES * STACK_DEPTH entries with a registered read, while the
// bump pointers and stack counts sit in flip-flops. An allocate takes from the first
// range with a slot left, popping its stack if that is not empty or else bumping its
// pointer, and answers slot 0 with status 1 when nothing is left. A free of slot 0
// does nothing; a free of the slot just below a bump pointer lowers that pointer;
// any other free is pushed onto the stack of the first range that holds it, with
// status 2 for a slot in no range and status 3 for a full stack. Both channels use
// valid/ready and a transfer happens when both are high. A free or a bump
// allocation enters the output register when it is accepted, if that register is
// free; an allocation that pops a stack goes through the READ state, since the popped
// slot comes from the stack memory's registered read. A new item is taken once the
// previous result has reached the output register, so the input side keeps moving
// while a finished result waits to be taken. The stack memory needs no clearing
// after reset: only entries below a range's stack count are ever read. Configuration
// writes go through cfg_write/cfg_index/cfg_data and must only be issued while the
// block is idle; writing a range's low register also resets that range's bump
// pointer and empties its stack.
module slot_range_allocator_core
  import sra_pkg::*;
#(
  parameter int NUM_RANGES  = 2,
  parameter int STACK_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [SLOT_W-1:0]      slot_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SLOT_W-1:0]      slot_out,
  output logic [1:0]             status,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int RangeW   = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int CountW   = $clog2(STACK_DEPTH + 1);
  localparam int MemDepth = NUM_RANGES * STACK_DEPTH;
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  typedef enum logic [1:0] {
    IDLE,
    READ,
    HOLD
  } state_t;

  state_t state;

  // Configuration and per-range state.
  logic [COUNT_REG_W-1:0] range_count;
  slot_t                  lo   [NUM_RANGES];
  slot_t                  hi   [NUM_RANGES];
  slot_t                  bump [NUM_RANGES];
  logic [CountW-1:0]      cnt  [NUM_RANGES];

  // A finished result that could not enter the output register yet.
  result_t hold;

  logic accept;
  logic out_free;
  logic out_valid_next;

  // Allocate decision.
  logic              a_found;
  logic              a_pop;
  logic [RangeW-1:0] a_sel;
  slot_t             a_slot;
  slot_t             bump_alloc [NUM_RANGES];

  // Free decision.
  logic              f_hit;
  logic [RangeW-1:0] f_sel;
  logic              f_lower;
  logic              f_full;
  status_t           f_status;
  logic              push;
  logic              pop;

  result_t imm;

  // Memory interface.
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;
  slot_t            rdata;

  // Configuration decode.
  logic              cfg_low;
  logic              cfg_high;
  logic [RangeW-1:0] cfg_rng;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The search visits the active ranges in order. Within a range a non-empty
  // stack wins over the bump pointer; a bump that hands out slot zero (a range
  // with low 0) still advances the pointer but lets the search go on.
  always_comb begin
    a_found = 1'b0;
    a_pop   = 1'b0;
    a_sel   = '0;
    a_slot  = '0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      bump_alloc[r] = bump[r];
      if (!a_found && (r < int'(range_count))) begin
        if (cnt[r] != '0) begin
          a_found = 1'b1;
          a_pop   = 1'b1;
          a_sel   = RangeW'(r);
        end else if (bump[r] < hi[r]) begin
          bump_alloc[r] = bump[r] + slot_t'(1);
          if (bump[r] != '0) begin
            a_found = 1'b1;
            a_sel   = RangeW'(r);
            a_slot  = bump[r];
          end
        end
      end
    end
  end

  // The first active range that holds the freed slot takes it.
  always_comb begin
    f_hit = 1'b0;
    f_sel = '0;
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (!f_hit && (r < int'(range_count)) && (slot_in >= lo[r]) && (slot_in < hi[r])) begin
        f_hit = 1'b1;
        f_sel = RangeW'(r);
      end
    end
    f_lower = (slot_in == (bump[f_sel] - slot_t'(1)));
    f_full  = (cnt[f_sel] == CountW'(STACK_DEPTH));
    if (slot_in == '0) begin
      f_status = ST_OK;
    end else if (!f_hit) begin
      f_status = ST_NO_RANGE;
    end else if (f_lower) begin
      f_status = ST_OK;
    end else if (f_full) begin
      f_status = ST_FULL;
    end else begin
      f_status = ST_OK;
    end
  end

  assign push = accept && (cmd == CMD_FREE) && (slot_in != '0) && f_hit && !f_lower && !f_full;
  assign pop  = accept && (cmd == CMD_ALLOC) && a_pop;

  // Each range owns a contiguous block of STACK_DEPTH entries in the memory.
  assign raddr = AddrW'(a_sel) * AddrW'(STACK_DEPTH) + AddrW'(cnt[a_sel] - CountW'(1));
  assign waddr = AddrW'(f_sel) * AddrW'(STACK_DEPTH) + AddrW'(cnt[f_sel]);

  // Result of an item that finishes in the cycle it is accepted.
  always_comb begin
    if (cmd == CMD_ALLOC) begin
      imm.slot   = (a_found && !a_pop) ? a_slot : '0;
      imm.status = a_found ? ST_OK : ST_EMPTY;
    end else begin
      imm.slot   = '0;
      imm.status = f_status;
    end
  end

  // The output register is loaded whenever a finished result meets a free
  // output slot; otherwise a pending transfer stays until it is taken.
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    case (state)
      IDLE: begin
        if (accept && !pop && out_free) begin
          out_valid_next = 1'b1;
        end
      end
      READ, HOLD: begin
        if (out_free) begin
          out_valid_next = 1'b1;
        end
      end
      default: begin
        out_valid_next = out_valid && !out_ready;
      end
    endcase
  end

  always_comb begin
    cfg_low  = 1'b0;
    cfg_high = 1'b0;
    cfg_rng  = '0;
    case (cfg_index)
      REG_RANGE0_LOW: begin
        cfg_low = 1'b1;
      end
      REG_RANGE0_HIGH: begin
        cfg_high = 1'b1;
      end
      REG_RANGE1_LOW: begin
        cfg_low = 1'b1;
        cfg_rng = RangeW'(1);
      end
      REG_RANGE1_HIGH: begin
        cfg_high = 1'b1;
        cfg_rng = RangeW'(1);
      end
      default: begin
        cfg_low  = 1'b0;
        cfg_high = 1'b0;
      end
    endcase
  end

  sra_stack_mem #(
    .DEPTH (MemDepth),
    .WIDTH (SLOT_W)
  ) u_stack_mem (
    .clk   (clk),
    .we    (push),
    .waddr (waddr),
    .wdata (slot_in),
    .re    (pop),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      out_valid   <= 1'b0;
      range_count <= '0;
      for (int r = 0; r < NUM_RANGES; r++) begin
        lo[r]   <= slot_t'(1);
        hi[r]   <= slot_t'(1);
        bump[r] <= slot_t'(1);
        cnt[r]  <= '0;
      end
    end else begin
      out_valid <= out_valid_next;

      case (state)
        IDLE: begin
          if (accept) begin
            if (cmd == CMD_ALLOC) begin
              for (int r = 0; r < NUM_RANGES; r++) begin
                bump[r] <= bump_alloc[r];
              end
              if (a_pop) begin
                cnt[a_sel] <= cnt[a_sel] - CountW'(1);
              end
            end else if ((slot_in != '0) && f_hit) begin
              if (f_lower) begin
                bump[f_sel] <= slot_in;
              end else if (!f_full) begin
                cnt[f_sel] <= cnt[f_sel] + CountW'(1);
              end
            end

            if (pop) begin
              state <= READ;
            end else if (out_free) begin
              slot_out <= imm.slot;
              status   <= imm.status;
            end else begin
              hold  <= imm;
              state <= HOLD;
            end
          end
        end
        READ: begin
          // The popped slot arrives from the memory read register.
          if (out_free) begin
            slot_out <= rdata;
            status   <= ST_OK;
            state    <= IDLE;
          end else begin
            hold.slot   <= rdata;
            hold.status <= ST_OK;
            state       <= HOLD;
          end
        end
        HOLD: begin
          if (out_free) begin
            slot_out <= hold.slot;
            status   <= hold.status;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      if (cfg_write) begin
        if (cfg_index == REG_RANGE_COUNT) begin
          range_count <= cfg_data[COUNT_REG_W-1:0];
        end
        for (int r = 0; r < NUM_RANGES; r++) begin
          if (cfg_rng == RangeW'(r)) begin
            if (cfg_low) begin
              lo[r]   <= cfg_data[SLOT_W-1:0];
              bump[r] <= cfg_data[SLOT_W-1:0];
              cnt[r]  <= '0;
            end
            if (cfg_high) begin
              hi[r] <= cfg_data[SLOT_W-1:0];
            end
          end
        end
      end
    end
  end

endmodule

// ===== verif/slot_range_allocator_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for slot_range_allocator_core: directed and random traffic.
module slot_range_allocator_core_tb
  import sra_pkg::*;
();

  localparam int NUM_R       = 2;
  localparam int STACK_D     = 64;
  localparam int ITEM_TARGET = 1700;
  localparam int MAX_GAP     = 12;
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOW_LIMIT  = 10;
  localparam int DRAIN_WAIT  = 20;

  // Indexes past the last register exist on the port but select nothing.
  localparam cfg_index_t LAST_REG = REG_RANGE1_HIGH;
  localparam int         TOP_INDEX = (1 << CFG_INDEX_W) - 1;

  // Mirror of the allocator. It keeps its own copy of the range registers,
  // bump pointers and free stacks, works out the answer of every accepted
  // request, and queues the answers in order until the block returns them.
  class slot_pool_mirror;
    logic [COUNT_REG_W-1:0] count_reg;
    slot_t   low_reg [NUM_R];
    slot_t   high_reg[NUM_R];
    slot_t   bump    [NUM_R];
    int      depth   [NUM_R];
    slot_t   stack   [NUM_R][STACK_D];
    result_t owed[$];
    slot_t   held[$];
    int      errors;

    function new();
      count_reg = '0;
      for (int r = 0; r < NUM_R; r++) begin
        low_reg[r]  = slot_t'(1);
        high_reg[r] = slot_t'(1);
        bump[r]     = slot_t'(1);
        depth[r]    = 0;
      end
      errors = 0;
    endfunction

    function void clear_range(int r, slot_t lo);
      low_reg[r] = lo;
      bump[r]    = lo;
      depth[r]   = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RANGE_COUNT: count_reg = data[COUNT_REG_W-1:0];
        REG_RANGE0_LOW:  clear_range(0, data);
        REG_RANGE0_HIGH: high_reg[0] = data;
        REG_RANGE1_LOW:  clear_range(1, data);
        REG_RANGE1_HIGH: high_reg[1] = data;
        default: ;
      endcase
    endfunction

    function int active_ranges();
      return (count_reg < NUM_R) ? int'(count_reg) : NUM_R;
    endfunction

    // Pop the range's stack if it holds anything, else bump; zero means nothing.
    function slot_t take_from(int r);
      slot_t s;
      if (depth[r] > 0) begin
        depth[r] = depth[r] - 1;
        return stack[r][depth[r]];
      end
      if (bump[r] < high_reg[r]) begin
        s       = bump[r];
        bump[r] = s + 1'b1;
        return s;
      end
      return '0;
    endfunction

    function status_t give_back(slot_t s);
      slot_t below;
      if (s == '0) return ST_OK;
      for (int r = 0; r < active_ranges(); r++) begin
        if (s >= low_reg[r] && s < high_reg[r]) begin
          below = bump[r] - 1'b1;
          if (s == below) begin
            bump[r] = s;
            return ST_OK;
          end
          if (depth[r] >= STACK_D) return ST_FULL;
          stack[r][depth[r]] = s;
          depth[r] = depth[r] + 1;
          return ST_OK;
        end
      end
      return ST_NO_RANGE;
    endfunction

    function result_t serve_request(logic c, slot_t s);
      result_t res;
      res.slot   = '0;
      res.status = ST_EMPTY;
      if (c == CMD_FREE) begin
        res.status = give_back(s);
      end else begin
        // A bumped slot zero counts as no slot, so the search moves on.
        for (int r = 0; r < active_ranges() && res.status != ST_OK; r++) begin
          res.slot = take_from(r);
          if (res.slot != '0) res.status = ST_OK;
        end
      end
      return res;
    endfunction

    function void note_request(logic c, slot_t s);
      result_t res;
      res = serve_request(c, s);
      owed.push_back(res);
      if (c == CMD_ALLOC && res.status == ST_OK) held.push_back(res.slot);
    endfunction

    function void check_answer(slot_t s, status_t st);
      result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("[%0t] result with none outstanding: slot_out=%0d status=%0d",
                   $time, s, st);
      end else begin
        want = owed.pop_front();
        if (want.slot !== s || want.status !== st) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("[%0t] expected slot_out=%0d status=%0d, got slot_out=%0d status=%0d",
                     $time, want.slot, want.status, s, st);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic                   cmd       = CMD_ALLOC;
  slot_t                  slot_in   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  slot_t                  slot_out;
  status_t                status;
  logic                   cfg_write = 1'b0;
  cfg_index_t             cfg_index = REG_RANGE_COUNT;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  slot_pool_mirror pool;
  int  items_sent   = 0;
  int  quiet_cycles = 0;
  // When set, the matching side runs back to back with no idle cycles.
  bit  in_burst     = 1'b0;
  bit  out_burst    = 1'b0;

  slot_range_allocator_core #(
    .NUM_RANGES  (NUM_R),
    .STACK_DEPTH (STACK_D)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .slot_in   (slot_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_out  (slot_out),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run in which neither channel moves for this long is hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until the transfer.
  // Valid is left high afterwards, so a back-to-back request never drops it;
  // stop_requests() lowers it when the stream pauses.
  task automatic send_item(logic c, slot_t s);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    slot_in  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pool.note_request(c, s);
    items_sent++;
  endtask

  // Stop the request stream, wait until every answer has come back, and then
  // let the block settle so it is surely idle before registers change.
  task automatic stop_requests();
    in_valid <= 1'b0;
    while (pool.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    pool.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Pick new ranges for a phase. Most are small, so ranges run dry and free
  // stacks fill; some hold slot zero, sit at the top of the slot space, are
  // inverted or empty, or repeat range 0 so that the first match wins.
  task automatic configure_random();
    slot_t                 lo;
    slot_t                 hi;
    logic [CFG_DATA_W-1:0] count_word;
    for (int r = 0; r < NUM_R; r++) begin
      case ($urandom_range(0, 9))
        0: begin
          lo = '0;
          hi = slot_t'($urandom_range(1, 40));
        end
        1: begin
          hi = 16'hFFFF;
          lo = hi - slot_t'($urandom_range(0, 30));
        end
        2: begin
          lo = slot_t'($urandom_range(1, 16'hFFFF));
          hi = slot_t'($urandom_range(1, lo));
        end
        3: begin
          lo = slot_t'($urandom_range(1, 16'hFFFF));
          hi = 16'hFFFF;
        end
        4: begin
          lo = pool.low_reg[0];
          hi = pool.high_reg[0];
        end
        default: begin
          lo = slot_t'($urandom_range(1, 16'hFF00));
          hi = lo + slot_t'($urandom_range(1, 48));
        end
      endcase
      // Now and then the low register is left alone, so the range keeps its
      // bump pointer and stack while only its upper bound moves.
      if ($urandom_range(0, 4) != 0)
        write_reg(r == 0 ? REG_RANGE0_LOW : REG_RANGE1_LOW, lo);
      write_reg(r == 0 ? REG_RANGE0_HIGH : REG_RANGE1_HIGH, hi);
    end
    case ($urandom_range(0, 7))
      0:       count_word = '0;
      1:       count_word = CFG_DATA_W'(3);
      default: count_word = CFG_DATA_W'($urandom_range(1, 2));
    endcase
    if ($urandom_range(0, 3) == 0)
      count_word[CFG_DATA_W-1:COUNT_REG_W] = (CFG_DATA_W - COUNT_REG_W)'($urandom);
    write_reg(REG_RANGE_COUNT, count_word);
    if ($urandom_range(0, 5) == 0)
      write_reg(cfg_index_t'($urandom_range(LAST_REG + 1, TOP_INDEX)), slot_t'($urandom));
  endtask

  // One phase of random requests. Most phases are well-formed traffic that
  // frees slots the block actually handed out, often the newest one so the
  // bump pointer gets lowered. Flood phases free random slots of range 0
  // until its stack overflows. Noise phases send anything at all.
  task automatic run_phase();
    int    flavor;
    int    n;
    int    alloc_pct;
    int    span;
    int    k;
    logic  c;
    slot_t s;
    flavor    = $urandom_range(0, 19);
    n         = (flavor >= 12 && flavor < 15) ? $urandom_range(70, 110)
                                              : $urandom_range(10, 80);
    alloc_pct = $urandom_range(25, 75);
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    span      = int'(pool.high_reg[0]) - int'(pool.low_reg[0]);
    repeat (n) begin
      if (flavor < 12) begin
        if (pool.held.size() == 0 || $urandom_range(1, 100) <= alloc_pct) begin
          c = CMD_ALLOC;
          s = slot_t'($urandom);
        end else if ($urandom_range(0, 19) == 0) begin
          c = CMD_FREE;
          s = '0;
        end else begin
          c = CMD_FREE;
          k = $urandom_range(0, 1) ? pool.held.size() - 1
                                   : $urandom_range(0, pool.held.size() - 1);
          s = pool.held[k];
          pool.held.delete(k);
        end
      end else if (flavor < 15) begin
        c = ($urandom_range(0, 9) == 0) ? CMD_ALLOC : CMD_FREE;
        s = (span > 0) ? slot_t'(pool.low_reg[0] + $urandom_range(0, span - 1))
                       : slot_t'($urandom);
      end else begin
        c = ($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE;
        s = slot_t'($urandom);
      end
      send_item(c, s);
    end
  endtask

  // Result side: stall a random number of cycles before each transfer, then
  // check the returned slot and status against the oldest owed answer.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      pool.check_answer(slot_out, status);
    end
  end

  initial begin
    pool = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Out of reset no range is in use: allocate finds nothing, a free of a
    // real slot belongs to no range, and a free of the null slot is fine.
    send_item(CMD_ALLOC, 16'hFFFF);
    send_item(CMD_FREE, 16'd5);
    send_item(CMD_FREE, 16'd0);
    stop_requests();

    // Range 0 starts at slot zero, range 1 sits at the top of the slot space.
    write_reg(REG_RANGE_COUNT, 16'd2);
    write_reg(REG_RANGE0_LOW, 16'd0);
    write_reg(REG_RANGE0_HIGH, 16'd3);
    write_reg(REG_RANGE1_LOW, 16'hFFFD);
    write_reg(REG_RANGE1_HIGH, 16'hFFFF);
    // The first bump of range 0 yields slot zero, which is dropped, so the
    // search falls through to range 1. Then both ranges run dry.
    repeat (5) send_item(CMD_ALLOC, 16'h0000);
    send_item(CMD_FREE, 16'hFFFE);   // just below the bump pointer: lowers it
    send_item(CMD_FREE, 16'd1);      // pushed onto the range 0 stack
    send_item(CMD_FREE, 16'hFFFF);   // the upper bound itself is outside
    send_item(CMD_FREE, 16'd3);
    send_item(CMD_FREE, 16'd0);
    send_item(CMD_ALLOC, 16'hFFFF);  // pops slot 1
    send_item(CMD_ALLOC, 16'h5555);  // range 0 is dry, bumps range 1 again
    send_item(CMD_FREE, 16'd2);      // lowers the range 0 bump pointer
    send_item(CMD_FREE, 16'd2);      // a double free is pushed as given
    send_item(CMD_ALLOC, 16'hAAAA);
    send_item(CMD_ALLOC, 16'h0000);
    stop_requests();

    // A count above the number of ranges is clamped, junk above the count
    // field is dropped, range 0 is inverted and range 1 is empty. Writes to
    // indexes past the last register change nothing.
    write_reg(REG_RANGE_COUNT, 16'hFFFF);
    write_reg(REG_RANGE0_LOW, 16'd10);
    write_reg(REG_RANGE0_HIGH, 16'd5);
    write_reg(REG_RANGE1_LOW, 16'hFFFF);
    write_reg(REG_RANGE1_HIGH, 16'hFFFF);
    write_reg(cfg_index_t'(LAST_REG + 1), 16'hFFFF);
    write_reg(cfg_index_t'(TOP_INDEX), 16'h0001);
    send_item(CMD_ALLOC, 16'h0000);
    send_item(CMD_FREE, 16'd7);
    send_item(CMD_FREE, 16'd10);

    while (items_sent < ITEM_TARGET) begin
      stop_requests();
      configure_random();
      run_phase();
    end

    // Drain: every answer must come back, and nothing may follow it.
    in_valid <= 1'b0;
    while (pool.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pool.errors == 0 && pool.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== slot_range_allocator_core.f =====
hdl/sra_pkg.sv
hdl/sra_stack_mem.sv
hdl/slot_range_allocator_core.sv
verif/slot_range_allocator_core_tb.sv
